FILE: hdl/bpsf_pkg.sv
// shared types, codes and constants for the bmp pixel stream filter
// no dependencies; used by bmp_pixel_stream_filter_unit
`timescale 1ns / 1ps
`default_nettype none

package bpsf_pkg;

    // mode register codes
    localparam logic [1:0] ModePass   = 2'd0;
    localparam logic [1:0] ModeInvert = 2'd1;
    localparam logic [1:0] ModeGray   = 2'd2;

    // status codes
    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusNotBm    = 2'd1;
    localparam logic [1:0] StatusBadDib   = 2'd2;
    localparam logic [1:0] StatusBadDepth = 2'd3;

    // header layout (byte positions)
    localparam int unsigned HdrLen       = 30;
    localparam logic [4:0]  PosId0       = 5'd0;
    localparam logic [4:0]  PosId1       = 5'd1;
    localparam logic [4:0]  PosOffsetLo  = 5'd10;
    localparam logic [4:0]  PosOffsetHi  = 5'd13;
    localparam logic [4:0]  PosDibLo     = 5'd14;
    localparam logic [4:0]  PosDibHi     = 5'd17;
    localparam logic [4:0]  PosWidthLo   = 5'd18;
    localparam logic [4:0]  PosWidthHi   = 5'd21;
    localparam logic [4:0]  PosHeightLo  = 5'd22;
    localparam logic [4:0]  PosHeightHi  = 5'd25;
    localparam logic [4:0]  PosDepthLo   = 5'd28;
    localparam logic [4:0]  PosDepthHi   = 5'd29;

    localparam logic [7:0]  CharB        = 8'h42;
    localparam logic [7:0]  CharM        = 8'h4D;
    localparam logic [31:0] DibSizeInfo  = 32'd40;
    localparam logic [15:0] DepthRgb24   = 16'd24;

    // one entry of the output pipeline: up to three beats to emit
    typedef struct packed {
        logic [1:0] cnt;     // number of beats, 0 when the byte is only held
        logic       gray;    // beats carry the gamma table value
        logic       last;    // final beat ends the file
        logic [1:0] status;
        logic [7:0] b0;
        logic [7:0] b1;
    } rec_t;

    // width of the exact integer compare used to build the gamma table
    localparam int unsigned GammaCalcW = 384;

    // srgb gamma of k/m scaled to 0..255, truncating; evaluated at elaboration
    function automatic logic [7:0] gamma_entry(input longint k, input longint m);
        logic [GammaCalcW-1:0] lhs;
        logic [GammaCalcW-1:0] rhs;
        logic [GammaCalcW-1:0] base;
        logic [7:0]            v;
        logic [7:0]            cand;
        v = '0;
        if (k * 64'sd10000000 <= 64'sd31308 * m) begin
            // linear segment: floor(3294.6 * k / m)
            for (int bit_i = 7; bit_i >= 0; bit_i--) begin
                cand = v | 8'(1 << bit_i);
                if (longint'(cand) * 64'sd10 * m <= 64'sd32946 * k) begin
                    v = cand;
                end
            end
        end else begin
            // power segment: k^5 * 269025^12 >= (1000v + 14025)^12 * m^5
            lhs = GammaCalcW'(1);
            for (int i = 0; i < 12; i++) lhs = lhs * GammaCalcW'(269025);
            for (int i = 0; i < 5; i++) lhs = lhs * GammaCalcW'(k);
            for (int bit_i = 7; bit_i >= 0; bit_i--) begin
                cand = v | 8'(1 << bit_i);
                base = GammaCalcW'(1000 * int'(cand) + 14025);
                rhs  = GammaCalcW'(1);
                for (int i = 0; i < 12; i++) rhs = rhs * base;
                for (int i = 0; i < 5; i++) rhs = rhs * GammaCalcW'(m);
                if (lhs >= rhs) begin
                    v = cand;
                end
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bmp_pixel_stream_filter_unit.sv
// bmp 24-bit byte stream filter: header check, pixel walk, invert and srgb grayscale
// depends on bpsf_pkg (codes, record type, gamma table function)
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] file byte, s_tlast end of file
//  m_      | out | m_tvalid/m_tready  | m_tdata[7:0] byte, [9:8] status, m_tlast
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data[1:0] mode
//
// one byte per cycle in unless the output record stalls or has beats left; each byte passes
// the register stages parse, luma sum, scale, divide by 255 and gamma rom, then the output
// a grayscale pixel gives no beat for blue and green and three beats for red,
// so three bytes in still take three beats out
// m_tready low while a beat is waiting freezes the whole pipeline and drops s_tready in the same cycle
// aresetn (synchronous, active low) clears mode, stream state and valid bits;
// the gamma rom is constant and needs no fill
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_stream_filter_unit #(
    parameter int unsigned LUMA_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,   // mode
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] in_byte
    input  wire logic        s_tlast,
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [7:0] out_byte, [9:8] status, rest zero
    output logic             m_tlast
);

    // fixed-point luma and divide-by-255 constants
    localparam int unsigned LumaOne    = 1 << LUMA_BITS;
    localparam int unsigned WeightR    = (2126 * LumaOne + 5000) / 10000;
    localparam int unsigned WeightB    = (722 * LumaOne + 5000) / 10000;
    localparam int unsigned WeightG    = LumaOne - WeightR - WeightB;
    localparam int unsigned AccW       = LUMA_BITS + 8;
    localparam int unsigned ScaleW     = 2 * LUMA_BITS + 8;
    localparam int unsigned Bias       = 255 * (LumaOne >> 1);
    localparam int unsigned RecipShift = LUMA_BITS + 16;
    localparam int unsigned RecipW     = LUMA_BITS + 9;
    localparam int unsigned ProdW      = AccW + RecipW;
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((64'd1 << RecipShift) + 64'd254) / 64'd255);
    localparam int unsigned GammaDepth = LumaOne;

    // configuration and stream state
    logic [1:0]  mode_reg;
    logic [1:0]  file_mode_reg,    file_mode_next;
    logic [31:0] byte_pos_reg,     byte_pos_next;
    logic [7:0]  first_id_reg,     first_id_next;
    logic [31:0] pixel_offset_reg, pixel_offset_next;
    logic [23:0] dib_size_reg,     dib_size_next;     // top byte checked as it arrives
    logic [31:0] width_reg,        width_next;
    logic [31:0] height_reg,       height_next;
    logic [7:0]  depth_reg,        depth_next;        // top byte checked as it arrives
    logic [31:0] row_reg,          row_next;
    logic [31:0] column_reg,       column_next;
    logic [1:0]  phase_reg,        phase_next;
    logic [1:0]  pad_reg,          pad_next;
    logic [7:0]  blue_reg,         blue_next;
    logic [7:0]  green_reg,        green_next;
    logic [1:0]  error_reg,        error_next;

    // pipeline
    logic                      adv;
    logic                      s_accept;
    bpsf_pkg::rec_t            rec_next;
    logic                      p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic                      p4_valid_reg, p5_valid_reg;
    bpsf_pkg::rec_t            p1_rec_reg, p2_rec_reg, p3_rec_reg, p4_rec_reg, p5_rec_reg;
    logic [7:0]                p1_green_reg, p1_blue_reg;
    logic [AccW-1:0]           acc_next, p2_acc_reg;
    logic [ScaleW-1:0]         scaled;
    logic [AccW-1:0]           q_next, p3_q_reg;
    logic [ProdW-1:0]          prod;
    logic [LUMA_BITS-1:0]      k_next, p4_k_reg;
    logic [7:0]                gray_reg;
    logic [1:0]                out_idx_reg;
    logic                      beat_last;
    logic                      rec_done;
    logic [7:0]                out_byte;

    // gamma rom, contents fixed at elaboration
    logic [7:0] gamma_rom [GammaDepth];

    for (genvar gk = 0; gk < GammaDepth; gk++) begin : g_rom
        localparam logic [7:0] Entry =
            bpsf_pkg::gamma_entry(longint'(gk), longint'(GammaDepth - 1));
        assign gamma_rom[gk] = Entry;
    end

    // ------------------------------------------------------------------
    // handshake: every stage moves together when the output can take a record
    // ------------------------------------------------------------------
    assign beat_last = (out_idx_reg == p5_rec_reg.cnt - 2'd1);
    assign rec_done  = p5_valid_reg &&
                       ((p5_rec_reg.cnt == 2'd0) || (m_tready && beat_last));
    assign adv       = !p5_valid_reg || rec_done;
    assign s_tready  = adv;
    assign s_accept  = s_tvalid && adv;

    // ------------------------------------------------------------------
    // parse stage: header fields, error checks, pixel walk
    // ------------------------------------------------------------------
    logic        in_header;
    logic        in_pixels;
    logic [4:0]  hdr_pos;
    logic [1:0]  hdr_byte;
    logic [31:0] column_inc;
    logic [1:0]  error_new;

    always_comb begin
        file_mode_next    = file_mode_reg;
        byte_pos_next     = byte_pos_reg;
        first_id_next     = first_id_reg;
        pixel_offset_next = pixel_offset_reg;
        dib_size_next     = dib_size_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        depth_next        = depth_reg;
        row_next          = row_reg;
        column_next       = column_reg;
        phase_next        = phase_reg;
        pad_next          = pad_reg;
        blue_next         = blue_reg;
        green_next        = green_reg;
        error_new         = error_reg;

        rec_next        = '0;
        rec_next.cnt    = 2'd1;
        rec_next.b0     = s_tdata;
        rec_next.last   = s_tlast;

        in_header  = (byte_pos_reg < 32'(bpsf_pkg::HdrLen));
        in_pixels  = !in_header && (error_reg == bpsf_pkg::StatusOk) &&
                     (byte_pos_reg >= pixel_offset_reg) && (width_reg != '0) &&
                     (row_reg < height_reg);
        hdr_pos    = byte_pos_reg[4:0];
        // little-endian byte lane of the 32-bit header fields at 10, 14, 18, 22
        hdr_byte   = hdr_pos[1:0] + 2'd2;
        column_inc = column_reg + 32'd1;

        if (s_accept) begin
            if (byte_pos_reg == '0) begin
                file_mode_next = mode_reg;
            end

            if (in_header) begin
                case (hdr_pos) inside
                    bpsf_pkg::PosId0: begin
                        first_id_next = s_tdata;
                    end
                    [bpsf_pkg::PosOffsetLo:bpsf_pkg::PosOffsetHi]: begin
                        pixel_offset_next[{hdr_byte, 3'b000} +: 8] = s_tdata;
                    end
                    [bpsf_pkg::PosDibLo:bpsf_pkg::PosDibHi]: begin
                        if (hdr_byte != 2'd3) begin
                            dib_size_next[{hdr_byte, 3'b000} +: 8] = s_tdata;
                        end
                    end
                    [bpsf_pkg::PosWidthLo:bpsf_pkg::PosWidthHi]: begin
                        width_next[{hdr_byte, 3'b000} +: 8] = s_tdata;
                    end
                    [bpsf_pkg::PosHeightLo:bpsf_pkg::PosHeightHi]: begin
                        height_next[{hdr_byte, 3'b000} +: 8] = s_tdata;
                    end
                    bpsf_pkg::PosDepthLo: begin
                        depth_next = s_tdata;
                    end
                    default: begin
                    end
                endcase

                // first failing check wins
                if (error_reg == bpsf_pkg::StatusOk) begin
                    case (hdr_pos)
                        bpsf_pkg::PosId1: begin
                            if (first_id_reg != bpsf_pkg::CharB || s_tdata != bpsf_pkg::CharM)
                                error_new = bpsf_pkg::StatusNotBm;
                        end
                        bpsf_pkg::PosDibHi: begin
                            if ({s_tdata, dib_size_reg} != bpsf_pkg::DibSizeInfo)
                                error_new = bpsf_pkg::StatusBadDib;
                        end
                        bpsf_pkg::PosDepthHi: begin
                            if ({s_tdata, depth_reg} != bpsf_pkg::DepthRgb24)
                                error_new = bpsf_pkg::StatusBadDepth;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (in_pixels) begin
                if (pad_reg != 2'd0) begin
                    // row padding passes through
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1) row_next = row_reg + 32'd1;
                end else begin
                    if (file_mode_reg == bpsf_pkg::ModeGray) begin
                        if (phase_reg == 2'd2) begin
                            rec_next.cnt  = 2'd3;
                            rec_next.gray = 1'b1;
                        end else if (s_tlast) begin
                            // file ends inside a pixel: held bytes go out unchanged
                            if (phase_reg == 2'd1) begin
                                rec_next.cnt = 2'd2;
                                rec_next.b0  = blue_reg;
                                rec_next.b1  = s_tdata;
                            end
                        end else begin
                            rec_next.cnt = 2'd0;
                            if (phase_reg == 2'd0) blue_next = s_tdata;
                            else green_next = s_tdata;
                        end
                    end else if (file_mode_reg == bpsf_pkg::ModeInvert) begin
                        rec_next.b0 = ~s_tdata;
                    end

                    if (phase_reg == 2'd2) begin
                        // pixel done: advance column, start padding at row end
                        phase_next = 2'd0;
                        if (column_inc == width_reg) begin
                            column_next = '0;
                            // padding (4 - 3w % 4) % 4 equals w % 4
                            if (width_reg[1:0] == 2'd0) row_next = row_reg + 32'd1;
                            else pad_next = width_reg[1:0];
                        end else begin
                            column_next = column_inc;
                        end
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end

            if (byte_pos_reg != '1) byte_pos_next = byte_pos_reg + 32'd1;
        end

        rec_next.status = error_new;
        error_next      = error_new;

        // end of file: back to the reset state, mode kept
        if (s_accept && s_tlast) begin
            file_mode_next    = '0;
            byte_pos_next     = '0;
            first_id_next     = '0;
            pixel_offset_next = '0;
            dib_size_next     = '0;
            width_next        = '0;
            height_next       = '0;
            depth_next        = '0;
            row_next          = '0;
            column_next       = '0;
            phase_next        = '0;
            pad_next          = '0;
            blue_next         = '0;
            green_next        = '0;
            error_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= bpsf_pkg::ModePass;
            file_mode_reg    <= '0;
            byte_pos_reg     <= '0;
            first_id_reg     <= '0;
            pixel_offset_reg <= '0;
            dib_size_reg     <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
            depth_reg        <= '0;
            row_reg          <= '0;
            column_reg       <= '0;
            phase_reg        <= '0;
            pad_reg          <= '0;
            blue_reg         <= '0;
            green_reg        <= '0;
            error_reg        <= '0;
        end else begin
            if (cfg_wr_en) mode_reg <= cfg_wr_data;
            file_mode_reg    <= file_mode_next;
            byte_pos_reg     <= byte_pos_next;
            first_id_reg     <= first_id_next;
            pixel_offset_reg <= pixel_offset_next;
            dib_size_reg     <= dib_size_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            depth_reg        <= depth_next;
            row_reg          <= row_next;
            column_reg       <= column_next;
            phase_reg        <= phase_next;
            pad_reg          <= pad_next;
            blue_reg         <= blue_next;
            green_reg        <= green_next;
            error_reg        <= error_next;
        end
    end

    // ------------------------------------------------------------------
    // grayscale datapath; records of every kind ride along to keep order
    // ------------------------------------------------------------------
    // luma sum with LUMA_BITS-bit fixed-point weights (red sits in b0)
    assign acc_next = AccW'(LUMA_BITS'(WeightR) * p1_rec_reg.b0) +
                      AccW'(LUMA_BITS'(WeightG) * p1_green_reg) +
                      AccW'(LUMA_BITS'(WeightB) * p1_blue_reg);

    // (acc * (2^L - 1) + rounding) / 2^L, then / 255 in the next stage
    assign scaled = (ScaleW'(p2_acc_reg) << LUMA_BITS) - ScaleW'(p2_acc_reg) +
                    ScaleW'(Bias);
    assign q_next = scaled[LUMA_BITS +: AccW];

    // divide by 255 through a reciprocal that is exact over the whole range
    assign prod   = ProdW'(p3_q_reg) * ProdW'(Recip);
    assign k_next = prod[RecipShift +: LUMA_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_rec_reg   <= rec_next;
            p1_green_reg <= green_reg;
            p1_blue_reg  <= blue_reg;
            p2_rec_reg   <= p1_rec_reg;
            p2_acc_reg   <= acc_next;
            p3_rec_reg   <= p2_rec_reg;
            p3_q_reg     <= q_next;
            p4_rec_reg   <= p3_rec_reg;
            p4_k_reg     <= k_next;
            p5_rec_reg   <= p4_rec_reg;
            gray_reg     <= gamma_rom[p4_k_reg];
        end
    end

    // ------------------------------------------------------------------
    // output: one record gives zero to three beats
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_idx_reg <= '0;
        end else if (adv) begin
            out_idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            out_idx_reg <= out_idx_reg + 2'd1;
        end
    end

    always_comb begin
        if (p5_rec_reg.gray) out_byte = gray_reg;
        else if (out_idx_reg == 2'd0) out_byte = p5_rec_reg.b0;
        else out_byte = p5_rec_reg.b1;
    end

    assign m_tvalid = p5_valid_reg && (p5_rec_reg.cnt != 2'd0);
    assign m_tdata  = {6'b000000, p5_rec_reg.status, out_byte};
    assign m_tlast  = p5_rec_reg.last && beat_last;

`ifndef ASSERT_OFF
    // a record never gives more beats than it holds
    a_beat_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_idx_reg < p5_rec_reg.cnt))
        else $error("output beat index beyond record count");

    // pending row padding never exceeds the width's remainder
    a_pad_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pad_reg != 2'd0) |-> (pad_reg <= width_reg[1:0]))
        else $error("row padding larger than width remainder");

    // the pixel phase walks blue, green, red only
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (phase_reg != 2'd3))
        else $error("pixel phase out of range");

    // a stalled output holds back the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule

`default_nettype wire
